>>> src/bmds_pkg.sv
// Shared constants and types for the 3x3 stride-2 box-mean downsampler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bmds_pkg;

  localparam int MAX_DIM    = 1024;
  localparam int PIXEL_BITS = 8;

  localparam int ADDR_W = $clog2(MAX_DIM);   // column / row position
  localparam int CFG_W  = 11;                // image_dim register width
  localparam int IDX_W  = 9;                 // out_row / out_col width
  localparam int COL_W  = PIXEL_BITS + 2;    // sum of three pixels
  localparam int SUM_W  = PIXEL_BITS + 4;    // sum of nine pixels plus rounding

  // divide by 9 as multiply by reciprocal; exact for every sum below 2**SUM_W
  localparam int DIV_SHIFT = SUM_W + 4;
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + 8) / 9;
  localparam int MULT_W    = DIV_SHIFT - 3;
  localparam int PROD_W    = SUM_W + MULT_W;

  // raster position of one pixel plus window-completion flags
  typedef struct packed {
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
    logic              row_done;
    logic              col_done;
    logic              frame_last;
  } pos_t;

  // one column entry of the line buffer: row one above and row two above
  typedef struct packed {
    logic [PIXEL_BITS-1:0] one;
    logic [PIXEL_BITS-1:0] two;
  } line_t;

endpackage

`default_nettype wire

>>> src/bmds_if.sv
// Valid/ready channel interfaces: pixel stream in, pooled results out.
// Depends on bmds_pkg for the pixel and index widths.
`default_nettype none

interface bmds_pix_if
  import bmds_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bmds_res_if
  import bmds_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] mean;
  logic [IDX_W-1:0]      out_row;
  logic [IDX_W-1:0]      out_col;
  logic                  frame_end;

  modport source (output valid, output mean, output out_row, output out_col,
                  output frame_end, input ready);
  modport sink   (input valid, input mean, input out_row, input out_col,
                  input frame_end, output ready);
endinterface

`default_nettype wire

>>> src/bmds_scan.sv
// Image size register and raster position counters.
// Depends on bmds_pkg (pos_t, ADDR_W, MAX_DIM).
`default_nettype none

module bmds_scan
  import bmds_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             advance,
  output pos_t                  pos
);

  logic [ADDR_W:0]   dim;
  logic [ADDR_W:0]   dim_next;
  logic [ADDR_W-1:0] dim_m1;
  logic [ADDR_W-1:0] row;
  logic [ADDR_W-1:0] col;
  logic              last_row;
  logic              last_col;

  // zero is taken as 1, anything above the line buffer depth as the depth
  always_comb begin
    if (cfg_data == '0) begin
      dim_next = (ADDR_W+1)'(1);
    end else if (32'(cfg_data) > 32'(MAX_DIM)) begin
      dim_next = (ADDR_W+1)'(MAX_DIM);
    end else begin
      dim_next = (ADDR_W+1)'(cfg_data);
    end
  end

  assign dim_m1   = ADDR_W'(dim - (ADDR_W+1)'(1));
  assign last_row = (row == dim_m1);
  assign last_col = (col == dim_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      dim <= (ADDR_W+1)'(MAX_DIM);
      row <= '0;
      col <= '0;
    end else if (cfg_we) begin
      // new size restarts the frame
      dim <= dim_next;
      row <= '0;
      col <= '0;
    end else if (advance) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + ADDR_W'(1);
      end else begin
        col <= col + ADDR_W'(1);
      end
    end
  end

  always_comb begin
    pos.row        = row;
    pos.col        = col;
    pos.row_done   = row[0] | last_row;
    pos.col_done   = col[0] | last_col;
    pos.frame_last = last_row & last_col;
  end

  a_row_in_range: assert property (@(posedge clk) disable iff (rst) row <= dim_m1)
    else $error("row counter beyond image size");
  a_col_in_range: assert property (@(posedge clk) disable iff (rst) col <= dim_m1)
    else $error("column counter beyond image size");
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
      cfg_we |=> (row == '0 && col == '0))
    else $error("size write did not restart the frame");

endmodule

`default_nettype wire

>>> src/bmds_linebuf.sv
// Two-row line buffer: one entry per column holds the pixels one and two rows up.
// Registered read, single write port. Depends on bmds_pkg (line_t, MAX_DIM).
`default_nettype none

module bmds_linebuf
  import bmds_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output line_t                  rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire line_t             wr_data
);

  line_t mem [MAX_DIM];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while the consuming stage is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/box_mean_3x3_stride2_downsampler.sv
// 3x3 average pooling, stride 2, over a square image streamed in raster order.
// Depends on bmds_pkg, bmds_if, bmds_scan and bmds_linebuf.
//
// Usage:
//   pixels  : valid/ready stream of image_dim x image_dim pixels, raster order.
//   results : valid/ready stream of rounded 3x3 means with their row and column
//             in the half-size image; frame_end marks the last one of a frame.
//   cfg_we / cfg_data : write of image_dim (0 acts as 1, above 1024 as 1024);
//             the write restarts the frame at row 0, column 0.
// A result is produced by the pixel that completes its window (odd row and odd
// column, or the last row / column of an odd-sized image); other pixels give none.
// Throughput: one pixel per cycle unless a stalled receiver blocks results. A
// result reaches the output register through a two-stage path: position and line
// buffer read, then window sum, divide by 9 and output register.
// When the receiver stalls, a finished result waits in the output register;
// the next pixel is still taken, and input ready drops only when a second
// result is blocked behind it.
// Reset sets image_dim to 1024 and restarts the frame. The line buffer is not
// cleared: rows above the top of a frame are masked to zero, and every row is
// written before the row below reads it.
`default_nettype none

module box_mean_3x3_stride2_downsampler
  import bmds_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  bmds_pix_if.sink              pixels,
  bmds_res_if.source            results
);

  pos_t                  pos;
  logic                  accept;
  logic                  b_valid;
  pos_t                  b_pos;
  logic [PIXEL_BITS-1:0] b_pix;
  logic                  b_result;
  logic                  b_adv;
  line_t                 rd_line;
  line_t                 wr_line;
  logic [PIXEL_BITS-1:0] up1;
  logic [PIXEL_BITS-1:0] up2;
  logic [COL_W-1:0]      vsum;
  logic [COL_W-1:0]      col_sum0;
  logic [COL_W-1:0]      col_sum1;
  logic [COL_W-1:0]      left1;
  logic [COL_W-1:0]      left2;
  logic [SUM_W-1:0]      total;
  logic [PROD_W-1:0]     prod;
  logic                  out_valid;

  assign accept = pixels.valid && pixels.ready;

  bmds_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .advance  (accept),
    .pos      (pos)
  );

  // second stage: line buffer data is valid here
  assign b_result     = b_pos.row_done && b_pos.col_done;
  assign b_adv        = b_valid && (!b_result || !out_valid || results.ready);
  assign pixels.ready = !b_valid || b_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_pos <= pos;
      b_pix <= pixels.pixel;
    end
  end

  assign wr_line.one = b_pix;
  assign wr_line.two = rd_line.one;

  // only an image one pixel wide reads a column in the cycle it is written,
  // and there every line read is masked to zero
  bmds_linebuf u_linebuf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (pos.col),
    .rd_data (rd_line),
    .wr_en   (b_adv),
    .wr_addr (b_pos.col),
    .wr_data (wr_line)
  );

  always_comb begin
    up1 = (b_pos.row != '0) ? rd_line.one : '0;
    up2 = (|b_pos.row[ADDR_W-1:1]) ? rd_line.two : '0;
    // even row: last row of an odd image, bottom padding row is zero
    if (b_pos.row[0]) begin
      vsum = COL_W'(up2) + COL_W'(up1) + COL_W'(b_pix);
    end else begin
      vsum = COL_W'(up1) + COL_W'(b_pix);
    end
    left1 = (b_pos.col != '0) ? col_sum0 : '0;
    left2 = (|b_pos.col[ADDR_W-1:1]) ? col_sum1 : '0;
    if (b_pos.col[0]) begin
      total = SUM_W'(left2) + SUM_W'(left1) + SUM_W'(vsum);
    end else begin
      total = SUM_W'(left1) + SUM_W'(vsum);
    end
    prod = PROD_W'(total + SUM_W'(4)) * PROD_W'(DIV_MULT);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col_sum0 <= '0;
      col_sum1 <= '0;
    end else if (b_adv) begin
      col_sum1 <= col_sum0;
      col_sum0 <= vsum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv && b_result) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_result) begin
      results.mean      <= PIXEL_BITS'(prod >> DIV_SHIFT);
      results.out_row   <= IDX_W'(b_pos.row >> 1);
      results.out_col   <= IDX_W'(b_pos.col >> 1);
      results.frame_end <= b_pos.frame_last;
    end
  end

  assign results.valid = out_valid;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !results.ready) |-> !(b_adv && b_result))
    else $error("held result overwritten");
  a_ready_low_cause: assert property (@(posedge clk) disable iff (rst)
      !pixels.ready |-> (b_valid && out_valid && !results.ready))
    else $error("input stalled without a blocked result");
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
      accept |=> b_valid)
    else $error("accepted item lost before second stage");
  a_frame_end_corner: assert property (@(posedge clk) disable iff (rst)
      (results.valid && results.frame_end) |-> (results.out_row == results.out_col))
    else $error("frame end off the diagonal corner");

endmodule

`default_nettype wire
